/* rtl/assert_macros.svh */
// assertion macros shared by the generator rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define MWCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MWCW_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define MWCW_ASSERT(lbl, clk, rst_n, prop, msg)

`define MWCW_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/mwcw_pkg.sv */
// types, codes and constants of the multiply-with-carry generator
// no dependencies; imported by every module of the block
package mwcw_pkg;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_DRAW   = 2'd0,
        FUNC_SIGNED = 2'd1,
        FUNC_LOAD   = 2'd2
    } t_func;

    // generator constants
    localparam logic [31:0] MWC_MULT   = 32'd65184;
    localparam logic [31:0] WEYL_STEP  = 32'd21611;
    localparam logic [31:0] MWC_RESET  = 32'd33331;
    localparam logic [31:0] WEYL_RESET = 32'd1;

    // raw draw width and modulo steps, one remainder bit per step
    localparam int RAW_W     = 16;
    localparam int DIV_STEPS = RAW_W;

    // default depth of the job queue, a power of two
    localparam int QUEUE_DEPTH_DEF = 2;

    // input item
    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] range;
        logic [31:0] load_mult;
        logic [31:0] load_stir;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        [15:0] random_value;
        logic signed [15:0] signed_value;
        logic        [31:0] mult_state;
        logic        [31:0] stir_state;
    } t_out_item;

    // job handed from the front to the back
    typedef struct packed {
        logic [1:0]       func;
        logic [RAW_W-1:0] raw;
        logic [14:0]      range;
        logic [31:0]      mult_state;
        logic [31:0]      stir_state;
    } t_job;

endpackage

/* rtl/mwcw_front.sv */
// front part: holds generator state, accepts items and builds jobs
// depends on mwcw_pkg
module mwcw_front
    import mwcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_push_valid,
    input  logic     i_push_ready,
    output t_job     o_job
);

    logic [31:0]      r_mwc;
    logic [31:0]      r_weyl;
    logic [31:0]      n_mwc;
    logic [31:0]      n_weyl;
    logic [31:0]      step_mwc;
    logic [31:0]      step_weyl;
    logic [RAW_W-1:0] raw;
    logic             accept;

    // handshake passes straight to the queue
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid;
    assign accept       = i_in_valid && i_push_ready;

    // one generator step from the current words
    assign step_mwc  = {16'd0, r_mwc[15:0]} * MWC_MULT + 32'd1 + {16'd0, r_mwc[31:16]};
    assign step_weyl = r_weyl + WEYL_STEP;

    // classify the item and form its job
    always_comb begin
        n_mwc  = r_mwc;
        n_weyl = r_weyl;
        raw    = '0;
        case (i_in_item.func)
            FUNC_DRAW, FUNC_SIGNED: begin
                n_mwc  = step_mwc;
                n_weyl = step_weyl;
                raw    = step_mwc[RAW_W-1:0] ^ step_weyl[RAW_W-1:0];
            end
            FUNC_LOAD: begin
                n_mwc  = i_in_item.load_mult;
                n_weyl = i_in_item.load_stir;
            end
            default: begin
                n_mwc  = r_mwc;
                n_weyl = r_weyl;
            end
        endcase
    end

    assign o_job.func       = i_in_item.func;
    assign o_job.raw        = raw;
    assign o_job.range      = i_in_item.range;
    assign o_job.mult_state = n_mwc;
    assign o_job.stir_state = n_weyl;

    // generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mwc  <= MWC_RESET;
            r_weyl <= WEYL_RESET;
        end else if (accept) begin
            r_mwc  <= n_mwc;
            r_weyl <= n_weyl;
        end
    end

endmodule

/* rtl/mwcw_queue.sv */
// short job queue between the front and the back
// depends on mwcw_pkg and assert_macros.svh
`include "assert_macros.svh"

module mwcw_queue
    import mwcw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    // depth must be a power of two so the pointers wrap on their own
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `MWCW_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "queue overfilled")
    `MWCW_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count != '0) || (r_wr_ptr == r_rd_ptr), "queue empty but pointers differ")
    `MWCW_ASSERT(a_full_ptrs, i_clk, i_rst_n, (r_count != FULL_CNT) || (r_wr_ptr == r_rd_ptr), "queue full but pointers differ")

endmodule

/* rtl/mwcw_back.sv */
// back part: bit-serial modulo for signed draws and the output register
// depends on mwcw_pkg and assert_macros.svh
`include "assert_macros.svh"

module mwcw_back
    import mwcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_valid,
    output logic      o_pop_ready,
    input  t_job      i_job,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    t_job             r_job, n_job;
    logic [RAW_W-1:0] r_rem, n_rem;
    logic [RAW_W-1:0] r_shift, n_shift;
    logic [RAW_W-1:0] r_div, n_div;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic             pop;
    logic             slot_free;
    logic [RAW_W:0]   trial;
    logic [RAW_W:0]   diff;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_pop_ready = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // one restoring remainder step
    assign trial = {r_rem, r_shift[RAW_W-1]};
    assign diff  = trial - {1'b0, r_div};

    // next state and output
    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rem       = r_rem;
        n_shift     = r_shift;
        n_div       = r_div;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        pop         = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    if (i_job.func == FUNC_SIGNED) begin
                        pop     = 1'b1;
                        n_job   = i_job;
                        n_rem   = '0;
                        n_shift = i_job.raw;
                        n_div   = {i_job.range, 1'b1};
                        n_count = '0;
                        n_state = S_DIV;
                    end else if (slot_free) begin
                        pop                = 1'b1;
                        n_out.random_value = i_job.raw;
                        n_out.signed_value = '0;
                        n_out.mult_state   = i_job.mult_state;
                        n_out.stir_state   = i_job.stir_state;
                        n_out_valid        = 1'b1;
                    end
                end
            end
            S_DIV: begin
                n_rem   = diff[RAW_W] ? trial[RAW_W-1:0] : diff[RAW_W-1:0];
                n_shift = {r_shift[RAW_W-2:0], 1'b0};
                n_count = r_count + 1'b1;
                if (r_count == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out.random_value = r_job.raw;
                    n_out.signed_value = $signed(r_rem - {1'b0, r_job.range});
                    n_out.mult_state   = r_job.mult_state;
                    n_out.stir_state   = r_job.stir_state;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
        r_job   <= n_job;
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_div   <= n_div;
        r_out   <= n_out;
    end

    `MWCW_ASSERT(a_div_odd, i_clk, i_rst_n, (r_state != S_DIV) || r_div[0], "modulo divisor is even")
    `MWCW_ASSERT(a_rem_below, i_clk, i_rst_n, (r_state == S_IDLE) || (r_rem < r_div), "remainder not below divisor")
    `MWCW_ASSERT(a_done_signed, i_clk, i_rst_n, (r_state == S_IDLE) || (r_job.func == FUNC_SIGNED), "modulo run on a non-signed job")

endmodule

/* rtl/mwc_weyl_random_generator.sv */
// top level of the multiply-with-carry generator with a weyl stir counter
// depends on mwcw_pkg, mwcw_front, mwcw_queue and mwcw_back
//
// usage: one item on the input channel (i_in_valid / o_in_ready, i_in_item)
// gives one result item on the output channel (o_out_valid / i_out_ready,
// o_out_item). func selects an unsigned draw, a signed draw within
// [-range, range] or a load of both state words; every result shows both
// words as they stand after its item.
// the front steps the generator in the cycle an item is accepted, so items
// enter back to back until the job queue is full.
// unsigned draws and loads go from the queue straight into the output
// register once it is free. a signed draw is taken, runs the bit-serial
// remainder (one bit a cycle) and is registered once the output is free;
// that remainder unit sets the throughput of signed draws.
// reset sets the words to 33331 and 1 and empties the queue and output.
// when the receiver stalls the result holds in the output register, the
// back stops at its next result, the queue fills, then o_in_ready drops.
module mwc_weyl_random_generator
    import mwcw_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    // generator state and job forming
    mwcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_job        (push_job)
    );

    // job queue
    mwcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    // remainder unit and output register
    mwcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_job       (pop_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
